// ===== rtl/ptsp_pkg.sv =====
// Shared types and constants of the pickle table stream parser.
package ptsp_pkg;

  // Opcodes of the supported pickle protocol 2 subset.
  localparam logic [7:0] OP_SHORT_STR = 8'h55;
  localparam logic [7:0] OP_UNICODE   = 8'h58;
  localparam logic [7:0] OP_INT1      = 8'h4B;
  localparam logic [7:0] OP_INT2      = 8'h4D;
  localparam logic [7:0] OP_INT4      = 8'h4A;
  localparam logic [7:0] OP_LONG1     = 8'h8A;
  localparam logic [7:0] OP_PROTO     = 8'h80;
  localparam logic [7:0] OP_BINPUT    = 8'h71;
  localparam logic [7:0] OP_LBINPUT   = 8'h72;
  localparam logic [7:0] OP_STOP      = 8'h2E;
  localparam logic [7:0] OP_APPEND    = 8'h61;
  localparam logic [7:0] OP_SETITEMS  = 8'h75;
  localparam logic [7:0] OP_MARK      = 8'h28;
  localparam logic [7:0] OP_EMPTYLIST = 8'h5D;
  localparam logic [7:0] OP_EMPTYDICT = 8'h7D;
  localparam logic [7:0] OP_TUPLE1    = 8'h85;
  localparam logic [7:0] OP_TUPLE2    = 8'h86;
  localparam logic [7:0] OP_TUPLE3    = 8'h87;

  // Parser phase.
  typedef enum logic [2:0] {
    PH_OPCODE   = 3'd0,
    PH_STRLEN   = 3'd1,
    PH_STRDATA  = 3'd2,
    PH_NUMBER   = 3'd3,
    PH_LONGLEN  = 3'd4,
    PH_LONGDATA = 3'd5,
    PH_SKIP     = 3'd6
  } phase_t;

  // Kind of a result.
  typedef enum logic [2:0] {
    KIND_STRBYTE = 3'd0,
    KIND_EMPTY   = 3'd1,
    KIND_NUMBER  = 3'd2,
    KIND_STOP    = 3'd3,
    KIND_BADOP   = 3'd4,
    KIND_TRUNC   = 3'd5
  } kind_t;

  // One input byte with its framing marks.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       table_start;
    logic       table_last;
  } item_t;

  // One decoded result.
  typedef struct packed {
    kind_t       item_kind;
    logic [7:0]  string_byte;
    logic        string_last;
    logic        is_prefix;
    logic [31:0] number_value;
    logic        is_size;
    logic [7:0]  bad_opcode;
  } result_t;

endpackage

// ===== rtl/ptsp_core.sv =====
// Parser state and combinational decode of one table byte.
module ptsp_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  ptsp_pkg::item_t   item,
  input  logic [31:0]       xor_key,
  output ptsp_pkg::result_t res,
  output logic              res_valid
);
  import ptsp_pkg::*;

  // Parser state registers.
  phase_t      phase;
  logic [31:0] remaining;
  logic [2:0]  position;
  logic [31:0] accum;
  logic        str_role;
  logic        num_role;
  logic        halted;

  phase_t      phase_next;
  logic [31:0] remaining_next;
  logic [2:0]  position_next;
  logic [31:0] accum_next;
  logic        str_role_next;
  logic        num_role_next;
  logic        halted_next;

  // State as seen by this byte, after an optional table start clear.
  phase_t      ph0;
  logic [31:0] rem0;
  logic [2:0]  pos0;
  logic [31:0] acc0;
  logic        srole0;
  logic        nrole0;
  logic        halt0;

  logic [7:0]  b;
  logic [31:0] rem_dec;
  logic [31:0] acc_take;
  logic [2:0]  pos_take;

  assign b = item.data_byte;

  // Clear the view of the state when a new table starts.
  always_comb begin
    if (item.table_start) begin
      ph0    = PH_OPCODE;
      rem0   = '0;
      pos0   = '0;
      acc0   = '0;
      srole0 = 1'b0;
      nrole0 = 1'b0;
      halt0  = 1'b0;
    end else begin
      ph0    = phase;
      rem0   = remaining;
      pos0   = position;
      acc0   = accum;
      srole0 = str_role;
      nrole0 = num_role;
      halt0  = halted;
    end
  end

  // Little-endian byte insertion; bytes past the fourth are dropped.
  always_comb begin
    rem_dec = rem0 - 32'd1;
    if (!pos0[2]) begin
      acc_take = acc0 | ({24'b0, b} << {pos0[1:0], 3'b000});
      pos_take = pos0 + 3'd1;
    end else begin
      acc_take = acc0;
      pos_take = pos0;
    end
  end

  // Next state and result of this byte.
  always_comb begin
    phase_next     = ph0;
    remaining_next = rem0;
    position_next  = pos0;
    accum_next     = acc0;
    str_role_next  = srole0;
    num_role_next  = nrole0;
    halted_next    = halt0;
    res            = '0;
    res_valid      = 1'b0;

    if (!halt0) begin
      unique case (ph0)
        PH_OPCODE: begin
          remaining_next = rem0;
          unique case (b) inside
            OP_SHORT_STR: begin
              phase_next = PH_STRLEN; remaining_next = 32'd1;
              position_next = '0; accum_next = '0;
            end
            OP_UNICODE: begin
              phase_next = PH_STRLEN; remaining_next = 32'd4;
              position_next = '0; accum_next = '0;
            end
            OP_INT1: begin
              phase_next = PH_NUMBER; remaining_next = 32'd1;
              position_next = '0; accum_next = '0;
            end
            OP_INT2: begin
              phase_next = PH_NUMBER; remaining_next = 32'd2;
              position_next = '0; accum_next = '0;
            end
            OP_INT4: begin
              phase_next = PH_NUMBER; remaining_next = 32'd4;
              position_next = '0; accum_next = '0;
            end
            OP_LONG1: begin
              phase_next = PH_LONGLEN; remaining_next = 32'd1;
              position_next = '0; accum_next = '0;
            end
            OP_PROTO, OP_BINPUT: begin
              phase_next = PH_SKIP; remaining_next = 32'd1;
              position_next = '0; accum_next = '0;
            end
            OP_LBINPUT: begin
              phase_next = PH_SKIP; remaining_next = 32'd4;
              position_next = '0; accum_next = '0;
            end
            OP_APPEND, OP_SETITEMS, OP_MARK, OP_EMPTYLIST, OP_EMPTYDICT,
            OP_TUPLE1, OP_TUPLE2, OP_TUPLE3: begin
              phase_next = PH_OPCODE;
            end
            OP_STOP: begin
              res.item_kind = KIND_STOP;
              res_valid     = 1'b1;
              halted_next   = 1'b1;
            end
            default: begin
              res.item_kind  = KIND_BADOP;
              res.bad_opcode = b;
              res_valid      = 1'b1;
              halted_next    = 1'b1;
            end
          endcase
        end
        PH_STRLEN: begin
          accum_next     = acc_take;
          position_next  = pos_take;
          remaining_next = rem_dec;
          if (rem_dec == '0) begin
            if (acc_take == '0) begin
              res.item_kind = KIND_EMPTY;
              res.is_prefix = srole0;
              res_valid     = 1'b1;
              str_role_next = ~srole0;
              phase_next    = PH_OPCODE;
            end else begin
              remaining_next = acc_take;
              phase_next     = PH_STRDATA;
            end
          end
        end
        PH_STRDATA: begin
          res.item_kind   = KIND_STRBYTE;
          res.string_byte = b;
          res.string_last = (rem0 == 32'd1);
          res.is_prefix   = srole0;
          res_valid       = 1'b1;
          remaining_next  = rem_dec;
          if (rem_dec == '0) begin
            str_role_next = ~srole0;
            phase_next    = PH_OPCODE;
          end
        end
        PH_NUMBER, PH_LONGDATA: begin
          accum_next     = acc_take;
          position_next  = pos_take;
          remaining_next = rem_dec;
          if (rem_dec == '0) begin
            res.item_kind    = KIND_NUMBER;
            res.number_value = acc_take ^ xor_key;
            res.is_size      = nrole0;
            res_valid        = 1'b1;
            num_role_next    = ~nrole0;
            phase_next       = PH_OPCODE;
          end
        end
        PH_LONGLEN: begin
          if (b == 8'd0) begin
            accum_next       = '0;
            res.item_kind    = KIND_NUMBER;
            res.number_value = xor_key;
            res.is_size      = nrole0;
            res_valid        = 1'b1;
            num_role_next    = ~nrole0;
            phase_next       = PH_OPCODE;
          end else begin
            phase_next     = PH_LONGDATA;
            remaining_next = {24'b0, b};
            position_next  = '0;
            accum_next     = '0;
          end
        end
        default: begin
          // Argument bytes of Proto and the Put opcodes are skipped.
          if (rem0 != '0) begin
            remaining_next = rem_dec;
          end
          if (rem0 == '0 || rem_dec == '0) begin
            phase_next = PH_OPCODE;
          end
        end
      endcase
    end

    // The last byte halts the parser and flags an unfinished item.
    if (item.table_last) begin
      if (!halted_next && phase_next != PH_OPCODE) begin
        res           = '0;
        res.item_kind = KIND_TRUNC;
        res_valid     = 1'b1;
      end
      halted_next = 1'b1;
      phase_next  = PH_OPCODE;
    end
  end

  // State update on each processed byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_OPCODE;
      remaining <= '0;
      position  <= '0;
      accum     <= '0;
      str_role  <= 1'b0;
      num_role  <= 1'b0;
      halted    <= 1'b0;
    end else if (step) begin
      phase     <= phase_next;
      remaining <= remaining_next;
      position  <= position_next;
      accum     <= accum_next;
      str_role  <= str_role_next;
      num_role  <= num_role_next;
      halted    <= halted_next;
    end
  end

endmodule

// ===== rtl/pickle_table_stream_parser.sv =====
// Top level of the pickle table stream parser: input and result registers around the core.
// Flow: a byte is captured in the input register and decoded by the core when it advances;
// its result, if any, is then held in the result register until the downstream side takes it.
// Throughput: one byte per cycle while results are taken; while a result waits, one more
// request can still enter the input register. The result register moves on whenever the
// downstream side takes its request.
// Reset (synchronous, active high) empties both registers, clears the parser state
// and sets the key to zero.
module pickle_table_stream_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  ptsp_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output ptsp_pkg::result_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [31:0]       cfg_data
);
  import ptsp_pkg::*;

  logic        stage_valid;
  item_t       stage;
  logic [31:0] xor_key;
  logic        advance;
  result_t     core_res;
  logic        core_res_valid;

  assign cfg_ready  = 1'b1;
  assign advance    = stage_valid && (!result_valid || result_ready);
  assign item_ready = !stage_valid || advance;

  // Key register.
  always_ff @(posedge clk) begin
    if (rst) begin
      xor_key <= '0;
    end else if (cfg_valid) begin
      xor_key <= cfg_data;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item_ready) begin
      stage_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      stage <= item;
    end
  end

  ptsp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .item      (stage),
    .xor_key   (xor_key),
    .res       (core_res),
    .res_valid (core_res_valid)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= core_res_valid;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && core_res_valid) begin
      result <= core_res;
    end
  end

endmodule
